// File: rtl/core/priority_layer_compositor_macros.svh
// Assertion macros used by the compositor checker.
`ifndef PRIORITY_LAYER_COMPOSITOR_MACROS_SVH
`define PRIORITY_LAYER_COMPOSITOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PLC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PLC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/plc_pkg.sv
// Shared types and constants of the priority layer compositor.
package plc_pkg;

    localparam int LAYERS_DEF      = 4;
    localparam int LAYER_WORDS_DEF = 4096;
    localparam int DEST_DIM_DEF    = 4096;

    localparam int RECT_REGS = 4;
    localparam int COLOR_W   = 32;
    localparam int SEL_W     = 2;
    localparam int PADDR_IN_W = 12;
    localparam int COORD_IN_W = 12;
    localparam int DADDR_W   = 24;
    localparam int WIN_W     = 3;
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;

    localparam logic [WIN_W-1:0] NO_LAYER = 3'd4;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    typedef enum logic [2:0] {
        REG_LAYER0_RECT,
        REG_LAYER1_RECT,
        REG_LAYER2_RECT,
        REG_LAYER3_RECT,
        REG_LAYER_COUNT,
        REG_DEST_ORIGIN,
        REG_DEST_SIZE,
        REG_UNRENDERED
    } t_reg_idx;

endpackage

// File: rtl/core/plc_ifs.sv
// Request and result channel interfaces of the compositor.
interface plc_req_if;
    import plc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [SEL_W-1:0]      layer_select;
    logic [PADDR_IN_W-1:0] pixel_address;
    logic [COLOR_W-1:0]    pixel_color;
    logic [COORD_IN_W-1:0] column;
    logic [COORD_IN_W-1:0] row;

    modport source (output valid, func, layer_select, pixel_address, pixel_color,
                    column, row, input ready);
    modport sink   (input valid, func, layer_select, pixel_address, pixel_color,
                    column, row, output ready);
endinterface

interface plc_res_if;
    import plc_pkg::*;
    logic               valid;
    logic               ready;
    logic [DADDR_W-1:0] dest_address;
    logic [COLOR_W-1:0] out_color;
    logic [WIN_W-1:0]   winning_layer;

    modport source (output valid, dest_address, out_color, winning_layer, input ready);
    modport sink   (input valid, dest_address, out_color, winning_layer, output ready);
endinterface

// File: rtl/core/priority_layer_compositor.sv
// Priority layer compositor: layer pixel stores, render sequencer and APB registers.
//
// Requests arrive on i_req. A load request (func = 0) writes one 32-bit pixel
// into a layer store and is taken whenever the block is idle; it gives no result.
// A render request (func = 1) names a destination column and row. The block
// walks the active layers from layer 0 up with one shared multiply-add unit:
// per layer S_OFS forms the offsets and cover test, S_MUL the address
// multiply-add, S_ADR the bound check and store read, and S_CHK the alpha
// test when the read was made. i_req.ready stays low while a render runs.
// Renders outside the destination give no result.
// Results leave through an output register on o_res; the next request is taken
// while a result waits. If the receiver stalls, a finished render waits for the
// output register to drain before the block goes ready again.
// Reset (synchronous, active low) clears the configuration registers and the sequencer; the
// layer stores are not cleared and must be loaded before they are rendered.
// Registers sit on the APB port at byte address 8*i, 64-bit data.
module priority_layer_compositor #(
    parameter int LAYERS      = plc_pkg::LAYERS_DEF,
    parameter int LAYER_WORDS = plc_pkg::LAYER_WORDS_DEF,
    parameter int DEST_DIM    = plc_pkg::DEST_DIM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    plc_req_if.sink                      i_req,
    plc_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plc_pkg::PADDR_W-1:0]  paddr,
    input  logic [plc_pkg::PDATA_W-1:0]  pwdata,
    output logic [plc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import plc_pkg::*;

    localparam int L_USED    = (LAYERS < RECT_REGS) ? LAYERS : RECT_REGS;
    localparam int LSEL_W    = (L_USED > 1) ? $clog2(L_USED) : 1;
    localparam int WORD_W    = $clog2(LAYER_WORDS);
    localparam int LAW       = LSEL_W + WORD_W;
    localparam int MEM_DEPTH = L_USED << WORD_W;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_DEST, S_OFS, S_MUL, S_ADR, S_CHK, S_DONE
    } t_state;

    // configuration registers
    logic [63:0] r_rect [RECT_REGS];
    logic [2:0]  r_layer_count;
    logic [31:0] r_dest_origin;
    logic [31:0] r_dest_size;
    logic [31:0] r_unrendered;

    logic [COLOR_W-1:0] r_pixels [MEM_DEPTH];
    logic [COLOR_W-1:0] r_rdata;

    t_state                r_state;
    logic [COORD_IN_W-1:0] r_col;
    logic [COORD_IN_W-1:0] r_row;
    logic signed [17:0]    r_px;
    logic signed [17:0]    r_py;
    logic signed [18:0]    r_dx;
    logic signed [18:0]    r_dy;
    logic                  r_cover;
    logic [32:0]           r_laddr;
    logic [2:0]            r_layer;
    logic [DADDR_W-1:0]    r_dest;
    logic [COLOR_W-1:0]    r_color;
    logic [WIN_W-1:0]      r_winner;
    logic                  r_out_valid;
    logic [DADDR_W-1:0]    r_out_dest;
    logic [COLOR_W-1:0]    r_out_color;
    logic [WIN_W-1:0]      r_out_winner;

    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic               req_fire;
    logic               out_load;
    logic               wr_en;
    logic [MEM_AW-1:0]  wr_addr;
    logic               rd_en;
    logic [MEM_AW-1:0]  rd_addr;
    logic [16:0]        dw;
    logic [16:0]        dh;
    logic [2:0]         layer_lim;
    logic               last_layer;
    logic [63:0]        cur_rect;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic [15:0]        lw;
    logic [15:0]        lh;
    logic signed [17:0] px_c;
    logic signed [17:0] py_c;
    logic signed [18:0] dx_c;
    logic signed [18:0] dy_c;
    logic [16:0]        mul_a;
    logic [16:0]        mul_b;
    logic [33:0]        mul_p;

    // ---------------- APB registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[PADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RECT_REGS; i++) begin
                r_rect[i] <= '0;
            end
            r_layer_count <= '0;
            r_dest_origin <= '0;
            r_dest_size   <= '0;
            r_unrendered  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LAYER0_RECT, REG_LAYER1_RECT, REG_LAYER2_RECT, REG_LAYER3_RECT: begin
                    r_rect[paddr[4:3]] <= pwdata;
                end
                REG_LAYER_COUNT: r_layer_count <= pwdata[2:0];
                REG_DEST_ORIGIN: r_dest_origin <= pwdata[31:0];
                REG_DEST_SIZE:   r_dest_size   <= pwdata[31:0];
                REG_UNRENDERED:  r_unrendered  <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_LAYER0_RECT, REG_LAYER1_RECT, REG_LAYER2_RECT, REG_LAYER3_RECT: begin
                prdata = r_rect[paddr[4:3]];
            end
            REG_LAYER_COUNT: prdata = {61'd0, r_layer_count};
            REG_DEST_ORIGIN: prdata = {32'd0, r_dest_origin};
            REG_DEST_SIZE:   prdata = {32'd0, r_dest_size};
            REG_UNRENDERED:  prdata = {32'd0, r_unrendered};
            default:         prdata = '0;
        endcase
    end

    // ---------------- layer stores ----------------
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    // loads to a layer at or past L_USED, or past the store depth, are dropped
    assign wr_en = req_fire && (i_req.func == FUNC_LOAD)
                 && (3'(i_req.layer_select) < 3'(L_USED))
                 && (17'(i_req.pixel_address) < 17'(LAYER_WORDS));
    assign wr_addr = MEM_AW'((LAW'(i_req.layer_select) << WORD_W)
                             | LAW'(WORD_W'(i_req.pixel_address)));
    assign rd_en   = (r_state == S_ADR) && r_cover && (r_laddr < 33'(LAYER_WORDS));
    assign rd_addr = MEM_AW'((LAW'(r_layer) << WORD_W) | LAW'(r_laddr[WORD_W-1:0]));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pixels[wr_addr] <= i_req.pixel_color;
        end
        if (rd_en) begin
            r_rdata <= r_pixels[rd_addr];
        end
    end

    // ---------------- datapath ----------------
    assign dw = ({1'b0, r_dest_size[15:0]}  > 17'(DEST_DIM)) ? 17'(DEST_DIM)
                                                            : {1'b0, r_dest_size[15:0]};
    assign dh = ({1'b0, r_dest_size[31:16]} > 17'(DEST_DIM)) ? 17'(DEST_DIM)
                                                            : {1'b0, r_dest_size[31:16]};
    assign layer_lim  = (r_layer_count > 3'(L_USED)) ? 3'(L_USED) : r_layer_count;
    assign last_layer = (3'(r_layer + 3'd1) >= layer_lim);

    assign cur_rect = r_rect[r_layer[1:0]];
    assign lx = cur_rect[15:0];
    assign ly = cur_rect[31:16];
    assign lw = cur_rect[47:32];
    assign lh = cur_rect[63:48];

    assign px_c = 18'($signed(r_dest_origin[15:0]))  + $signed({6'd0, r_col});
    assign py_c = 18'($signed(r_dest_origin[31:16])) + $signed({6'd0, r_row});
    assign dx_c = 19'(r_px) - 19'(lx);
    assign dy_c = 19'(r_py) - 19'(ly);

    // shared multiplier: destination row offset, then each layer's row offset
    always_comb begin
        if (r_state == S_DEST) begin
            mul_a = dh - 17'(r_row) - 17'd1;
            mul_b = dw;
        end else begin
            mul_a = {1'b0, 16'(lh - r_dy[15:0] - 16'd1)};
            mul_b = {1'b0, lw};
        end
    end
    assign mul_p = mul_a * mul_b;

    // finished render moves into the output register when it is free or draining
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_layer     <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire && (i_req.func == FUNC_RENDER)) begin
                        r_col   <= i_req.column;
                        r_row   <= i_req.row;
                        r_state <= S_DEST;
                    end
                end
                S_DEST: begin
                    r_px     <= px_c;
                    r_py     <= py_c;
                    r_dest   <= mul_p[DADDR_W-1:0] + {12'd0, r_col};
                    r_color  <= r_unrendered;
                    r_winner <= NO_LAYER;
                    r_layer  <= '0;
                    if ((17'(r_col) >= dw) || (17'(r_row) >= dh)) begin
                        r_state <= S_IDLE;
                    end else if (layer_lim == 3'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_OFS;
                    end
                end
                S_OFS: begin
                    r_dx    <= dx_c;
                    r_dy    <= dy_c;
                    r_cover <= !dx_c[18] && (dx_c[17:0] < 18'(lw))
                            && !dy_c[18] && (dy_c[17:0] < 18'(lh));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // bottom-up layer word address
                    r_laddr <= 33'(mul_p[31:0]) + 33'(r_dx[15:0]);
                    r_state <= S_ADR;
                end
                S_ADR: begin
                    if (rd_en) begin
                        r_state <= S_CHK;
                    end else if (last_layer) begin
                        r_state <= S_DONE;
                    end else begin
                        r_layer <= r_layer + 3'd1;
                        r_state <= S_OFS;
                    end
                end
                S_CHK: begin
                    if (r_rdata[31:24] != 8'd0) begin
                        r_color  <= r_rdata;
                        r_winner <= r_layer;
                        r_state  <= S_DONE;
                    end else if (last_layer) begin
                        r_state <= S_DONE;
                    end else begin
                        r_layer <= r_layer + 3'd1;
                        r_state <= S_OFS;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_dest   <= r_dest;
                        r_out_color  <= r_color;
                        r_out_winner <= r_winner;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.dest_address  = r_out_dest;
    assign o_res.out_color     = r_out_color;
    assign o_res.winning_layer = r_out_winner;

endmodule

// File: rtl/core/plc_checker.sv
// Port-level checker for the compositor, bound to the top level.
`include "priority_layer_compositor_macros.svh"

module plc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_req_func,
    input logic                         i_res_valid,
    input logic                         i_res_ready,
    input logic [plc_pkg::DADDR_W-1:0]  i_res_dest_address,
    input logic [plc_pkg::COLOR_W-1:0]  i_res_out_color,
    input logic [plc_pkg::WIN_W-1:0]    i_res_winning_layer,
    input logic                         i_pready
);
    import plc_pkg::*;

    `PLC_ASSERT_IMP(a_pready_high, 1'b1, i_pready, "pready dropped")

    `PLC_ASSERT_NXT(a_res_hold, i_res_valid && !i_res_ready,
        i_res_valid && $stable(i_res_dest_address) && $stable(i_res_out_color) && $stable(i_res_winning_layer),
        "stalled result changed")

    `PLC_ASSERT_NXT(a_render_busy, i_req_valid && i_req_ready && (i_req_func == FUNC_RENDER),
        !i_req_ready, "ready right after a render request")

    `PLC_ASSERT_NXT(a_load_silent,
        i_req_valid && i_req_ready && (i_req_func == FUNC_LOAD) && !i_res_valid,
        !i_res_valid, "load request produced a result")

endmodule

bind priority_layer_compositor plc_checker u_plc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_req_func          (i_req.func),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_res_dest_address  (o_res.dest_address),
    .i_res_out_color     (o_res.out_color),
    .i_res_winning_layer (o_res.winning_layer),
    .i_pready            (pready)
);

// File: verif/tb_priority_layer_compositor.sv
// Self-checking testbench for the priority layer compositor: random loads and renders.
module tb_priority_layer_compositor;
    timeunit 1ns;
    timeprecision 1ps;

    import plc_pkg::*;

    localparam int LAYERS        = LAYERS_DEF;
    localparam int WORDS         = LAYER_WORDS_DEF;
    localparam int DIM           = DEST_DIM_DEF;
    localparam int STORE_DEPTH   = LAYERS * WORDS;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 170;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 3000;

    typedef struct packed {
        logic                  func;
        logic [SEL_W-1:0]      layer_select;
        logic [PADDR_IN_W-1:0] pixel_address;
        logic [COLOR_W-1:0]    pixel_color;
        logic [COORD_IN_W-1:0] column;
        logic [COORD_IN_W-1:0] row;
    } t_pixel_req;

    typedef struct packed {
        logic [DADDR_W-1:0] dest_address;
        logic [COLOR_W-1:0] out_color;
        logic [WIN_W-1:0]   winning_layer;
    } t_pixel_out;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    plc_req_if req_ch ();
    plc_res_if res_ch ();

    priority_layer_compositor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register shadow, updated as each write lands
    logic [63:0]        cfg_rect [RECT_REGS];
    logic [2:0]         cfg_count;
    logic [31:0]        cfg_origin;
    logic [31:0]        cfg_size;
    logic [COLOR_W-1:0] cfg_unrendered;

    bit [COLOR_W-1:0] store_pix [STORE_DEPTH];     // layer stores as the block holds them
    bit [COLOR_W-1:0] plan_pix [STORE_DEPTH];      // layer stores as queued so far
    bit               plan_written [STORE_DEPTH];

    t_pixel_req req_backlog [$];
    t_pixel_out due_pixels [$];
    t_pixel_req on_bus;
    t_pixel_out predicted;
    t_pixel_out want;

    int planned    = 0;
    int n_req_acc  = 0;
    int n_res_acc  = 0;
    int n_loads    = 0;
    int n_renders  = 0;
    int n_settings = 0;
    int fail_count = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int quiet      = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int clip_dim(input logic [15:0] v);
        return (int'(v) > DIM) ? DIM : int'(v);
    endfunction

    function automatic int active_layers();
        return (int'(cfg_count) > LAYERS) ? LAYERS : int'(cfg_count);
    endfunction

    // Scene position of a destination pixel; 0 when clipped away.
    function automatic bit dest_to_scene(input logic [COORD_IN_W-1:0] col, row,
                                         output int px, py);
        px = int'($signed(cfg_origin[15:0])) + int'(col);
        py = int'($signed(cfg_origin[31:16])) + int'(row);
        return int'(col) < clip_dim(cfg_size[15:0]) && int'(row) < clip_dim(cfg_size[31:16]);
    endfunction

    // Word of layer li under a scene pixel; 0 if uncovered or past the store.
    function automatic bit layer_word(input int li, input int px, py, output int word);
        logic [63:0] r;
        int          lx, ly, lw, lh;
        longint      a;
        r  = cfg_rect[li];
        lx = int'($signed(r[15:0]));
        ly = int'($signed(r[31:16]));
        lw = int'(r[47:32]);
        lh = int'(r[63:48]);
        if (px < lx || px >= lx + lw || py < ly || py >= ly + lh)
            return 1'b0;
        // layer rows are stored bottom-up
        a    = longint'(lh - (py - ly) - 1) * longint'(lw) + longint'(px - lx);
        word = int'(a);
        return a < WORDS;
    endfunction

    function automatic bit composite_pixel(input t_pixel_req rq, output t_pixel_out pixel);
        int                 px, py, w, dw, dh;
        logic [COLOR_W-1:0] pix;
        dw = clip_dim(cfg_size[15:0]);
        dh = clip_dim(cfg_size[31:16]);
        pixel.dest_address  = DADDR_W'((dh - int'(rq.row) - 1) * dw + int'(rq.column));
        pixel.out_color     = cfg_unrendered;
        pixel.winning_layer = NO_LAYER;
        if (!dest_to_scene(rq.column, rq.row, px, py))
            return 1'b0;
        for (int li = 0; li < active_layers(); li++) begin
            if (layer_word(li, px, py, w)) begin
                pix = store_pix[li * WORDS + w];
                if (pix[31:24] != 8'd0) begin
                    pixel.out_color     = pix;
                    pixel.winning_layer = WIN_W'(li);
                    return 1'b1;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic t_pixel_req random_request();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        return noise[$bits(t_pixel_req)-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] random_pixel();
        logic [COLOR_W-1:0] c;
        c = $urandom();
        if ($urandom_range(0, 3) == 0)
            c[31:24] = 8'd0;
        return c;
    endfunction

    function automatic void queue_load(input logic [SEL_W-1:0] sel,
                                       input logic [PADDR_IN_W-1:0] addr,
                                       input logic [COLOR_W-1:0] color);
        t_pixel_req rq;
        rq               = random_request();
        rq.func          = FUNC_LOAD;
        rq.layer_select  = sel;
        rq.pixel_address = addr;
        rq.pixel_color   = color;
        plan_pix[int'(sel) * WORDS + int'(addr)]     = color;
        plan_written[int'(sel) * WORDS + int'(addr)] = 1'b1;
        req_backlog = {req_backlog, rq};
        planned++;
    endfunction

    // Any layer word the render will read gets loaded first if it never was.
    function automatic void queue_render(input logic [COORD_IN_W-1:0] col, row);
        t_pixel_req rq;
        int         px, py, w, slot;
        if (dest_to_scene(col, row, px, py)) begin
            for (int li = 0; li < active_layers(); li++) begin
                if (layer_word(li, px, py, w)) begin
                    slot = li * WORDS + w;
                    if (!plan_written[slot])
                        queue_load(SEL_W'(li), PADDR_IN_W'(w), random_pixel());
                    if (plan_pix[slot][31:24] != 8'd0)
                        break;
                end
            end
        end
        rq        = random_request();
        rq.func   = FUNC_RENDER;
        rq.column = col;
        rq.row    = row;
        req_backlog = {req_backlog, rq};
        planned++;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LAYER0_RECT, REG_LAYER1_RECT, REG_LAYER2_RECT, REG_LAYER3_RECT:
                cfg_rect[idx] = value;
            REG_LAYER_COUNT: cfg_count      = value[2:0];
            REG_DEST_ORIGIN: cfg_origin     = value[31:0];
            REG_DEST_SIZE:   cfg_size       = value[31:0];
            REG_UNRENDERED:  cfg_unrendered = value[31:0];
            default: ;
        endcase
    endtask

    // Setting 0 is the directed one with a random unrendered color; the others are random with extremes mixed in.
    task automatic program_phase(input int ph);
        logic [15:0]  ox, oy, dw, dh, lx, ly, lw, lh;
        logic [63:0]  rects [RECT_REGS];
        logic [2:0]   cnt;
        logic [31:0]  bg;
        int           k;
        ox  = 16'($urandom_range(0, 32) - 16);
        oy  = 16'($urandom_range(0, 32) - 16);
        dw  = 16'($urandom_range(1, 48));
        dh  = 16'($urandom_range(1, 48));
        bg  = $urandom();
        cnt = 3'($urandom_range(1, 4));
        case (ph)
            2: begin
                ox  = 16'h8000;
                oy  = 16'h8000;
                cnt = 3'd7;
            end
            3: begin
                cnt = 3'd0;
                bg  = 32'h0;
            end
            4: begin
                dw = 16'd1;
                bg = 32'hFFFF_FFFF;
            end
            5: begin
                ox = 16'h7FF0;
                oy = 16'h7FF0;
            end
            6: begin
                dh  = 16'd1;
                cnt = 3'd4;
            end
            default: ;
        endcase
        for (int i = 0; i < RECT_REGS; i++) begin
            k  = $urandom_range(0, 99);
            lx = ox + 16'($urandom_range(0, 48) - 8);
            ly = oy + 16'($urandom_range(0, 48) - 8);
            lw = 16'($urandom_range(1, 40));
            lh = 16'($urandom_range(1, 40));
            if (k < 15) begin
                if (k[0]) lw = 16'd0;
                else      lh = 16'd0;
            end else if (k < 30) begin
                lx = ox - 16'($urandom_range(0, 100));
                ly = oy - 16'($urandom_range(0, 100));
                lw = 16'($urandom_range(64, 65535));
                lh = 16'($urandom_range(64, 65535));
            end
            rects[i] = (k >= 92) ? '1 : {lh, lw, ly, lx};
        end
        if (ph == 0) begin
            rects = '{64'h0010_0010_0000_0000, 64'hFFFF_FFFF_8000_8000,
                      64'h0008_0000_0004_0004, 64'h0008_0008_0064_0064};
            cnt = 3'd7;
            ox  = 16'd0;
            oy  = 16'd0;
            dw  = 16'hFFFF;
            dh  = 16'hFFFF;
        end
        for (int i = 0; i < RECT_REGS; i++)
            write_reg(t_reg_idx'(i), rects[i]);
        write_reg(REG_LAYER_COUNT, 64'(cnt));
        write_reg(REG_DEST_ORIGIN, 64'({oy, ox}));
        write_reg(REG_DEST_SIZE, 64'({dh, dw}));
        write_reg(REG_UNRENDERED, 64'(bg));
        n_settings++;
    endtask

    // Sampled on the falling edge so the driver's updates have settled.
    task automatic drain();
        while (req_backlog.size() != 0 || req_ch.valid || due_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int dw, dh, k, stop_at;
        req_ch.valid         = 1'b0;
        req_ch.func          = FUNC_LOAD;
        req_ch.layer_select  = '0;
        req_ch.pixel_address = '0;
        req_ch.pixel_color   = '0;
        req_ch.column        = '0;
        req_ch.row           = '0;
        res_ch.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        i_rst_n              = 1'b0;
        for (int i = 0; i < RECT_REGS; i++)
            cfg_rect[i] = '0;
        cfg_count      = '0;
        cfg_origin     = '0;
        cfg_size       = '0;
        cfg_unrendered = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset destination is empty, so this render is dropped
        queue_render(12'd0, 12'd0);
        queue_load(2'd3, 12'hFFF, 32'h0);
        queue_load(2'd0, 12'h000, 32'hFFFF_FFFF);
        drain();

        // full-size destination, saturated layer count, a huge layer past the store,
        // an empty layer and a small one at column and row 100
        program_phase(0);
        queue_load(2'd1, 12'hFFF, 32'h0100_0000);
        queue_load(2'd2, 12'h000, 32'h00FF_FFFF);
        queue_load(2'd0, 12'd240, 32'h00FF_FFFF);
        queue_render(12'd0, 12'd0);
        queue_load(2'd0, 12'd240, 32'h0100_0000);
        queue_render(12'd0, 12'd0);
        queue_render(12'd15, 12'd15);
        queue_render(12'd16, 12'd16);
        queue_render(12'd5, 12'd5);
        queue_render(12'd100, 12'd100);
        queue_render(12'd107, 12'd107);
        queue_render(12'd2000, 12'd2000);
        queue_render(12'hFFF, 12'hFFF);
        queue_render(12'd0, 12'hFFF);
        queue_render(12'hFFF, 12'd0);

        for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
            drain();
            program_phase(ph);
            dw      = clip_dim(cfg_size[15:0]);
            dh      = clip_dim(cfg_size[31:16]);
            stop_at = planned + PHASE_ITEMS;
            while (planned < stop_at) begin
                k = $urandom_range(0, 99);
                if (k < 65)
                    queue_render(COORD_IN_W'($urandom_range(0, dw - 1)),
                                 COORD_IN_W'($urandom_range(0, dh - 1)));
                else if (k < 75)
                    queue_render(COORD_IN_W'($urandom()), COORD_IN_W'($urandom()));
                else
                    queue_load(SEL_W'($urandom_range(0, 3)),
                               ($urandom_range(0, 1) != 0) ? PADDR_IN_W'($urandom_range(0, 1599))
                                                           : PADDR_IN_W'($urandom()),
                               random_pixel());
            end
        end
        drain();

        $display("Ran %0d requests (%0d loads, %0d renders) over %0d register settings;",
                 n_req_acc, n_loads, n_renders, n_settings);
        $display("%0d composited pixels compared, %0d mismatches.", n_res_acc, fail_count);
        if (fail_count == 0) begin
            $display("priority_layer_compositor test passed");
        end else begin
            $display("priority_layer_compositor test failed");
        end
        $finish;
    end

    // request driver; the shadow stores and expectations move on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                n_req_acc <= n_req_acc + 1;
                if (on_bus.func == FUNC_LOAD) begin
                    store_pix[int'(on_bus.layer_select) * WORDS + int'(on_bus.pixel_address)] =
                        on_bus.pixel_color;
                    n_loads++;
                end else begin
                    n_renders++;
                    if (composite_pixel(on_bus, predicted))
                        due_pixels = {due_pixels, predicted};
                end
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_backlog.size() != 0 &&
                    !((n_req_acc < 400 || n_req_acc >= 700) && $urandom_range(0, 99) < 10)) begin
                    on_bus = req_backlog.pop_front();
                    req_ch.func          <= on_bus.func;
                    req_ch.layer_select  <= on_bus.layer_select;
                    req_ch.pixel_address <= on_bus.pixel_address;
                    req_ch.pixel_color   <= on_bus.pixel_color;
                    req_ch.column        <= on_bus.column;
                    req_ch.row           <= on_bus.row;
                    req_ch.valid         <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its request side
    always @(posedge i_clk) begin
        if (!hold_done && n_res_acc >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                n_res_acc <= n_res_acc + 1;
                if (due_pixels.size() == 0) begin
                    $error("unexpected pixel: dest_address %0d out_color %h winning_layer %0d",
                           res_ch.dest_address, res_ch.out_color, res_ch.winning_layer);
                    fail_count++;
                end else begin
                    want = due_pixels.pop_front();
                    if (res_ch.dest_address !== want.dest_address) begin
                        $error("dest_address: expected %0d, got %0d",
                               want.dest_address, res_ch.dest_address);
                        fail_count++;
                    end
                    if (res_ch.out_color !== want.out_color) begin
                        $error("out_color: expected %h, got %h", want.out_color, res_ch.out_color);
                        fail_count++;
                    end
                    if (res_ch.winning_layer !== want.winning_layer) begin
                        $error("winning_layer: expected %0d, got %0d",
                               want.winning_layer, res_ch.winning_layer);
                        fail_count++;
                    end
                end
            end
            res_ch.ready <= (hold_left == 0) &&
                            ((n_res_acc >= 250 && n_res_acc < 450) || $urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("priority_layer_compositor test failed");
            $finish;
        end
    end

endmodule
